// ===== hdl/triangle_closest_point_to_origin_core_macros.svh =====
// assertion macros for the triangle closest point core
// no dependencies; included by files that check their own logic
`ifndef TRIANGLE_CLOSEST_POINT_TO_ORIGIN_CORE_MACROS_SVH
`define TRIANGLE_CLOSEST_POINT_TO_ORIGIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define TCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define TCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCP_ASSERT_IMP(lbl, ante, cons, msg)
`define TCP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/tcp_pkg.sv =====
// shared constants, types and width helpers for the triangle closest point core
// no dependencies
`default_nettype none
package tcp_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 12;
    localparam int FRONT_Q_DEPTH   = 4;
    localparam int OUT_Q_DEPTH     = 2;

    // per-item status flags passed from front to back and out
    typedef struct packed {
        logic degenerate;
        logic interior;
    } tcp_flags_t;

    // width of the shifted dot products
    function automatic int tcp_sum_width(int cw, int fb);
        return 2 * (cw + 1) + 2 - fb;
    endfunction

    // width of det and the barycentric numerators
    function automatic int tcp_lam_width(int cw, int fb);
        return 2 * tcp_sum_width(cw, fb) + 1;
    endfunction

    // width of one front-to-back transfer, flags excluded
    function automatic int tcp_fq_width(int cw, int fb);
        return 6 * cw + 6 * (cw + 1) + 3 * tcp_lam_width(cw, fb);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/tcp_fifo.sv =====
// small register queue, power-of-two depth, head visible without a read cycle
// depends on nothing
`default_nettype none
module tcp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end
endmodule
`default_nettype wire

// ===== hdl/tcp_front.sv =====
// front pipeline: edges, dot products, det and barycentric numerators, flags
// depends on tcp_pkg
`default_nettype none
module tcp_front
    import tcp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [3*COORD_WIDTH-1:0]       a_in,
    input  logic [3*COORD_WIDTH-1:0]       b_in,
    input  logic [3*COORD_WIDTH-1:0]       c_in,
    input  logic [3*COORD_WIDTH-1:0]       q_in,
    output logic                           out_valid,
    output logic [tcp_fq_width(COORD_WIDTH, FRAC_BITS)-1:0] out_data,
    output tcp_flags_t                     out_flags
);
    localparam int CW  = COORD_WIDTH;
    localparam int VW  = CW + 1;
    localparam int PRW = 2 * VW;
    localparam int DW  = PRW + 2;
    localparam int SW  = tcp_sum_width(COORD_WIDTH, FRAC_BITS);
    localparam int LW  = tcp_lam_width(COORD_WIDTH, FRAC_BITS);
    localparam int SDW = 6 * CW + 6 * VW;

    logic [4:0]               valid_reg;
    logic [SDW-1:0]           side_reg [5];
    logic signed [PRW-1:0]    p11_reg [3];
    logic signed [PRW-1:0]    p12_reg [3];
    logic signed [PRW-1:0]    p22_reg [3];
    logic signed [PRW-1:0]    pa1_reg [3];
    logic signed [PRW-1:0]    pa2_reg [3];
    logic signed [SW-1:0]     d11_reg, d12_reg, d22_reg, e1_reg, e2_reg;
    logic signed [2*SW-1:0]   m_reg [6];
    logic signed [LW-1:0]     det_reg, l1_reg, l2_reg;
    logic signed [LW-1:0]     det5_reg, l15_reg, l25_reg;
    tcp_flags_t               flags_reg;

    logic signed [CW-1:0]     a_c [3];
    logic signed [CW-1:0]     b_c [3];
    logic signed [CW-1:0]     c_c [3];
    logic signed [VW-1:0]     v1_c [3];
    logic signed [VW-1:0]     v2_c [3];
    logic [3*VW-1:0]          v1_pk, v2_pk;
    logic [SDW-1:0]           side_next;
    logic signed [DW-1:0]     s11, s12, s22, sa1, sa2;
    logic signed [LW:0]       lsum, dext;
    tcp_flags_t               flags_next;

    // edge vectors
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_c[k]  = $signed(a_in[k*CW +: CW]);
            b_c[k]  = $signed(b_in[k*CW +: CW]);
            c_c[k]  = $signed(c_in[k*CW +: CW]);
            v1_c[k] = VW'(b_c[k]) - VW'(a_c[k]);
            v2_c[k] = VW'(c_c[k]) - VW'(a_c[k]);
            v1_pk[k*VW +: VW] = v1_c[k];
            v2_pk[k*VW +: VW] = v2_c[k];
        end
        side_next = {q_in, a_in, v2_pk, v1_pk};
    end

    // dot product sums with floor shift
    always_comb
    begin
        s11 = DW'(p11_reg[0]) + DW'(p11_reg[1]) + DW'(p11_reg[2]);
        s12 = DW'(p12_reg[0]) + DW'(p12_reg[1]) + DW'(p12_reg[2]);
        s22 = DW'(p22_reg[0]) + DW'(p22_reg[1]) + DW'(p22_reg[2]);
        sa1 = DW'(pa1_reg[0]) + DW'(pa1_reg[1]) + DW'(pa1_reg[2]);
        sa2 = DW'(pa2_reg[0]) + DW'(pa2_reg[1]) + DW'(pa2_reg[2]);
    end

    // degenerate and interior tests
    always_comb
    begin
        lsum = (LW+1)'(l1_reg) + (LW+1)'(l2_reg);
        dext = (LW+1)'(det_reg);
        flags_next.degenerate = det_reg[LW-1] || (det_reg == '0);
        flags_next.interior   = !l1_reg[LW-1] && !l2_reg[LW-1] && (lsum <= dext);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p11_reg[k] <= v1_c[k] * v1_c[k];
                p12_reg[k] <= v1_c[k] * v2_c[k];
                p22_reg[k] <= v2_c[k] * v2_c[k];
                pa1_reg[k] <= PRW'(a_c[k]) * PRW'(v1_c[k]);
                pa2_reg[k] <= PRW'(a_c[k]) * PRW'(v2_c[k]);
            end
            side_reg[0] <= side_next;
            for (int s = 1; s < 5; s++)
                side_reg[s] <= side_reg[s-1];

            d11_reg <= SW'(s11 >>> FRAC_BITS);
            d12_reg <= SW'(s12 >>> FRAC_BITS);
            d22_reg <= SW'(s22 >>> FRAC_BITS);
            e1_reg  <= SW'(sa1 >>> FRAC_BITS);
            e2_reg  <= SW'(sa2 >>> FRAC_BITS);

            m_reg[0] <= d11_reg * d22_reg;
            m_reg[1] <= d12_reg * d12_reg;
            m_reg[2] <= e2_reg * d12_reg;
            m_reg[3] <= e1_reg * d22_reg;
            m_reg[4] <= e1_reg * d12_reg;
            m_reg[5] <= e2_reg * d11_reg;

            det_reg <= LW'(m_reg[0]) - LW'(m_reg[1]);
            l1_reg  <= LW'(m_reg[2]) - LW'(m_reg[3]);
            l2_reg  <= LW'(m_reg[4]) - LW'(m_reg[5]);

            det5_reg  <= det_reg;
            l15_reg   <= l1_reg;
            l25_reg   <= l2_reg;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_data  = {side_reg[4], det5_reg, l15_reg, l25_reg};
    assign out_flags = flags_reg;
endmodule
`default_nettype wire

// ===== hdl/tcp_back.sv =====
// back pipeline: plane numerators, pipelined divide, saturation, length and visibility
// depends on tcp_pkg
`default_nettype none
module tcp_back
    import tcp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [tcp_fq_width(COORD_WIDTH, FRAC_BITS)-1:0] in_data,
    input  tcp_flags_t                     in_flags,
    output logic                           out_valid,
    output tcp_flags_t                     out_flags,
    output logic                           out_visible,
    output logic [3*(COORD_WIDTH+1)-1:0]   out_cp,
    output logic [2*COORD_WIDTH-1:0]       out_dsq
);
    localparam int CW  = COORD_WIDTH;
    localparam int VW  = CW + 1;
    localparam int LW  = tcp_lam_width(COORD_WIDTH, FRAC_BITS);
    localparam int LH  = LW / 2;
    localparam int HW  = LW - LH;
    localparam int NW  = VW + LW + 1;
    localparam int QB  = CW + 3;
    localparam int RW  = ((NW > LW + QB) ? NW : LW + QB) + 1;
    localparam int PW  = CW + 1;
    localparam int PQ  = QB + 2;
    localparam int SQW = 2 * PW;
    localparam int VPW = 2 * PW + 1;
    localparam int DQW = 2 * CW;
    localparam int AQW = 6 * CW;
    localparam int NS  = QB + 7;

    logic [NS-1:0]              valid_reg;

    logic signed [VW+LH:0]      pl1_reg [3];
    logic signed [VW+HW-1:0]    ph1_reg [3];
    logic signed [VW+LH:0]      pl2_reg [3];
    logic signed [VW+HW-1:0]    ph2_reg [3];
    logic signed [LW-1:0]       det1_reg, det2_reg;
    logic signed [NW-1:0]       num2_reg [3];
    logic [RW-1:0]              mag3_reg [3];
    logic [2:0]                 sgn3_reg;
    logic [RW-1:0]              den3_reg;
    logic [AQW-1:0]             aq1_reg, aq2_reg, aq3_reg;
    tcp_flags_t                 fl1_reg, fl2_reg, fl3_reg;

    logic [RW-1:0]              rem_reg [QB+1][3];
    logic [QB-1:0]              qm_reg  [QB+1][3];
    logic [2:0]                 sgn_reg [QB+1];
    logic [2:0]                 ovf_reg [QB+1];
    logic [RW-1:0]              den_reg [QB+1];
    logic [AQW-1:0]             aq_reg  [QB+1];
    tcp_flags_t                 fl_reg  [QB+1];

    logic signed [PW-1:0]       cp1_reg [3];
    logic [3*CW-1:0]            qy1_reg;
    tcp_flags_t                 flf1_reg;
    logic [SQW-1:0]             sq_reg [3];
    logic signed [VPW-1:0]      vp_reg [3];
    logic signed [PW-1:0]       cp2_reg [3];
    tcp_flags_t                 flf2_reg;
    logic [3*PW-1:0]            cp_out_reg;
    logic [DQW-1:0]             dsq_out_reg;
    logic                       vis_out_reg;
    tcp_flags_t                 fl_out_reg;

    logic signed [VW-1:0]       v1_c [3];
    logic signed [VW-1:0]       v2_c [3];
    logic signed [LW-1:0]       l1_c, l2_c;
    logic signed [LH:0]         lo1_c, lo2_c;
    logic signed [HW-1:0]       hi1_c, hi2_c;
    logic signed [QB:0]         qs_c [3];
    logic signed [PQ-1:0]       pw_c [3];
    logic signed [PW-1:0]       cp_next [3];
    logic signed [PW:0]         lev_c [3];
    logic [SQW+1:0]             dsum_c;
    logic signed [VPW+1:0]      vsum_c;
    logic [DQW-1:0]             dsq_next;
    logic                       vis_next;

    // unpack the front transfer and split the numerators for narrow multipliers
    always_comb
    begin
        l2_c  = $signed(in_data[0 +: LW]);
        l1_c  = $signed(in_data[LW +: LW]);
        lo1_c = $signed({1'b0, l1_c[LH-1:0]});
        lo2_c = $signed({1'b0, l2_c[LH-1:0]});
        hi1_c = $signed(l1_c[LW-1:LH]);
        hi2_c = $signed(l2_c[LW-1:LH]);
        for (int k = 0; k < 3; k++)
        begin
            v1_c[k] = $signed(in_data[3*LW + k*VW +: VW]);
            v2_c[k] = $signed(in_data[3*LW + 3*VW + k*VW +: VW]);
        end
    end

    // quotient sign, vertex add and saturation
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (ovf_reg[QB][k])
                qs_c[k] = sgn_reg[QB][k] ? -$signed({1'b0, {QB{1'b1}}})
                                         : $signed({1'b0, {QB{1'b1}}});
            else
                qs_c[k] = sgn_reg[QB][k] ? -$signed({1'b0, qm_reg[QB][k]})
                                         : $signed({1'b0, qm_reg[QB][k]});
            pw_c[k] = PQ'($signed(aq_reg[QB][k*CW +: CW])) + PQ'(qs_c[k]);
            if (pw_c[k][PQ-1:PW-1] == '0 || pw_c[k][PQ-1:PW-1] == '1)
                cp_next[k] = pw_c[k][PW-1:0];
            else if (pw_c[k][PQ-1])
                cp_next[k] = $signed({1'b1, {(PW-1){1'b0}}});
            else
                cp_next[k] = $signed({1'b0, {(PW-1){1'b1}}});
            lev_c[k] = (PW+1)'($signed(qy1_reg[k*CW +: CW])) - (PW+1)'(cp1_reg[k]);
        end
    end

    // squared length with saturation and visibility sign
    always_comb
    begin
        dsum_c = (SQW+2)'(sq_reg[0]) + (SQW+2)'(sq_reg[1]) + (SQW+2)'(sq_reg[2]);
        vsum_c = (VPW+2)'(vp_reg[0]) + (VPW+2)'(vp_reg[1]) + (VPW+2)'(vp_reg[2]);
        if (dsum_c[SQW+1:DQW] != '0)
            dsq_next = '1;
        else
            dsq_next = dsum_c[DQW-1:0];
        vis_next = !vsum_c[VPW+1] && (vsum_c != '0);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NS-2:0], in_valid};
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // partial products of edge times numerator
            for (int k = 0; k < 3; k++)
            begin
                pl1_reg[k] <= v1_c[k] * lo1_c;
                ph1_reg[k] <= v1_c[k] * hi1_c;
                pl2_reg[k] <= v2_c[k] * lo2_c;
                ph2_reg[k] <= v2_c[k] * hi2_c;
            end
            det1_reg <= $signed(in_data[2*LW +: LW]);
            aq1_reg  <= in_data[3*LW + 6*VW +: AQW];
            fl1_reg  <= in_flags;

            // plane numerator
            for (int k = 0; k < 3; k++)
                num2_reg[k] <= (NW'(ph1_reg[k]) <<< LH) + NW'(pl1_reg[k])
                             + (NW'(ph2_reg[k]) <<< LH) + NW'(pl2_reg[k]);
            det2_reg <= det1_reg;
            aq2_reg  <= aq1_reg;
            fl2_reg  <= fl1_reg;

            // magnitude and sign
            for (int k = 0; k < 3; k++)
            begin
                sgn3_reg[k] <= num2_reg[k][NW-1];
                mag3_reg[k] <= RW'(num2_reg[k][NW-1] ? -num2_reg[k] : num2_reg[k]);
            end
            den3_reg <= RW'($unsigned(det2_reg));
            aq3_reg  <= aq2_reg;
            fl3_reg  <= fl2_reg;

            // quotient range check
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[0][k] <= mag3_reg[k];
                qm_reg[0][k]  <= '0;
                ovf_reg[0][k] <= (mag3_reg[k] >= (den3_reg << QB));
            end
            sgn_reg[0] <= sgn3_reg;
            den_reg[0] <= den3_reg;
            aq_reg[0]  <= aq3_reg;
            fl_reg[0]  <= fl3_reg;

            // restoring divide, one quotient bit per stage
            for (int j = 1; j <= QB; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (rem_reg[j-1][k] >= (den_reg[j-1] << (QB - j)))
                    begin
                        rem_reg[j][k] <= rem_reg[j-1][k] - (den_reg[j-1] << (QB - j));
                        qm_reg[j][k]  <= qm_reg[j-1][k] | (QB'(1) << (QB - j));
                    end
                    else
                    begin
                        rem_reg[j][k] <= rem_reg[j-1][k];
                        qm_reg[j][k]  <= qm_reg[j-1][k];
                    end
                end
                sgn_reg[j] <= sgn_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                aq_reg[j]  <= aq_reg[j-1];
                fl_reg[j]  <= fl_reg[j-1];
            end

            // closest point
            for (int k = 0; k < 3; k++)
                cp1_reg[k] <= cp_next[k];
            qy1_reg  <= aq_reg[QB][3*CW +: 3*CW];
            flf1_reg <= fl_reg[QB];

            // squares and visibility products
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k]  <= $unsigned(SQW'(cp1_reg[k] * cp1_reg[k]));
                vp_reg[k]  <= cp1_reg[k] * lev_c[k];
                cp2_reg[k] <= cp1_reg[k];
            end
            flf2_reg <= flf1_reg;

            // result, zeroed for a degenerate triangle
            fl_out_reg.degenerate <= flf2_reg.degenerate;
            fl_out_reg.interior   <= flf2_reg.interior && !flf2_reg.degenerate;
            if (flf2_reg.degenerate)
            begin
                cp_out_reg  <= '0;
                dsq_out_reg <= '0;
                vis_out_reg <= 1'b0;
            end
            else
            begin
                cp_out_reg  <= {cp2_reg[2], cp2_reg[1], cp2_reg[0]};
                dsq_out_reg <= dsq_next;
                vis_out_reg <= vis_next;
            end
        end
    end

    assign out_valid   = valid_reg[NS-1];
    assign out_flags   = fl_out_reg;
    assign out_visible = vis_out_reg;
    assign out_cp      = cp_out_reg;
    assign out_dsq     = dsq_out_reg;
endmodule
`default_nettype wire

// ===== hdl/triangle_closest_point_to_origin_core.sv =====
// top level of the triangle closest point core
// depends on tcp_pkg, tcp_fifo, tcp_front, tcp_back and the macros header
//
// Input channel: a queue write port. A triangle (a, b, c) and a query point,
// signed fixed point, transfer at a clock edge with push high and full low.
// Result channel: a queue read port. While empty is low the oldest result sits
// on the result ports; it transfers at an edge with pop high and empty low.
// One triangle is taken per cycle while full is low. The path from the input
// transfer to empty going low runs through five front stages, the middle
// queue, the back pipeline, whose length is set by the restoring divider at
// one quotient bit per stage, and the result queue.
// The front pipeline stalls only when the middle queue is full; the back
// pipeline stalls only when the result queue is full, so a receiver that
// stops popping backs the block up until full rises. Reset clears all
// queues and stage valid bits; nothing is lost or repeated across a stall.
`default_nettype none
`include "triangle_closest_point_to_origin_core_macros.svh"
module triangle_closest_point_to_origin_core
    import tcp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic signed [COORD_WIDTH-1:0]  a_x,
    input  logic signed [COORD_WIDTH-1:0]  a_y,
    input  logic signed [COORD_WIDTH-1:0]  a_z,
    input  logic signed [COORD_WIDTH-1:0]  b_x,
    input  logic signed [COORD_WIDTH-1:0]  b_y,
    input  logic signed [COORD_WIDTH-1:0]  b_z,
    input  logic signed [COORD_WIDTH-1:0]  c_x,
    input  logic signed [COORD_WIDTH-1:0]  c_y,
    input  logic signed [COORD_WIDTH-1:0]  c_z,
    input  logic signed [COORD_WIDTH-1:0]  query_x,
    input  logic signed [COORD_WIDTH-1:0]  query_y,
    input  logic signed [COORD_WIDTH-1:0]  query_z,
    output logic                           empty,
    input  logic                           pop,
    output logic                           degenerate,
    output logic signed [COORD_WIDTH:0]    closest_x,
    output logic signed [COORD_WIDTH:0]    closest_y,
    output logic signed [COORD_WIDTH:0]    closest_z,
    output logic [2*COORD_WIDTH-1:0]       distance_sq,
    output logic                           inside_res,
    output logic                           visible
);
    localparam int PW  = COORD_WIDTH + 1;
    localparam int DQW = 2 * COORD_WIDTH;
    localparam int FQD = tcp_fq_width(COORD_WIDTH, FRAC_BITS);
    localparam int FLW = $bits(tcp_flags_t);
    localparam int FQW = FQD + FLW;
    localparam int OQW = FLW + 1 + 3 * PW + DQW;

    logic             front_en, back_en;
    logic             in_xfer;
    logic             fq_push, fq_pop, fq_full, fq_empty;
    logic [FQD-1:0]   front_data;
    tcp_flags_t       front_flags;
    logic [FQW-1:0]   fq_dout;
    tcp_flags_t       fq_flags;
    logic             oq_push, oq_full;
    tcp_flags_t       back_flags;
    logic             back_vis;
    logic [3*PW-1:0]  back_cp;
    logic [DQW-1:0]   back_dsq;
    logic [OQW-1:0]   oq_dout;
    tcp_flags_t       oq_flags;
    logic             res_zero;

    // stall control: each half moves while its downstream queue has room
    assign front_en = !fq_full;
    assign back_en  = !oq_full;
    assign full     = !front_en;
    assign in_xfer  = push && front_en;
    assign fq_pop   = back_en && !fq_empty;

    // front half
    tcp_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (front_en),
        .in_valid  (in_xfer),
        .a_in      ({a_z, a_y, a_x}),
        .b_in      ({b_z, b_y, b_x}),
        .c_in      ({c_z, c_y, c_x}),
        .q_in      ({query_z, query_y, query_x}),
        .out_valid (fq_push),
        .out_data  (front_data),
        .out_flags (front_flags)
    );

    // queue between front and back
    tcp_fifo #(
        .WIDTH (FQW),
        .DEPTH (FRONT_Q_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   ({front_flags, front_data}),
        .pop   (fq_pop),
        .dout  (fq_dout),
        .full  (fq_full),
        .empty (fq_empty)
    );

    assign fq_flags = fq_dout[FQD +: FLW];

    // back half
    tcp_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (back_en),
        .in_valid    (fq_pop),
        .in_data     (fq_dout[FQD-1:0]),
        .in_flags    (fq_flags),
        .out_valid   (oq_push),
        .out_flags   (back_flags),
        .out_visible (back_vis),
        .out_cp      (back_cp),
        .out_dsq     (back_dsq)
    );

    // result queue
    tcp_fifo #(
        .WIDTH (OQW),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .din   ({back_flags, back_vis, back_cp, back_dsq}),
        .pop   (pop),
        .dout  (oq_dout),
        .full  (oq_full),
        .empty (empty)
    );

    // result fields
    assign oq_flags    = oq_dout[DQW + 3*PW + 1 +: FLW];
    assign degenerate  = oq_flags.degenerate;
    assign inside_res  = oq_flags.interior;
    assign visible     = oq_dout[DQW + 3*PW];
    assign closest_x   = $signed(oq_dout[DQW +: PW]);
    assign closest_y   = $signed(oq_dout[DQW + PW +: PW]);
    assign closest_z   = $signed(oq_dout[DQW + 2*PW +: PW]);
    assign distance_sq = oq_dout[DQW-1:0];

    // all result fields cleared
    assign res_zero = closest_x == '0 && closest_y == '0 && closest_z == '0
                   && distance_sq == '0 && !inside_res && !visible;

    // checks
    `TCP_ASSERT_IMP(a_degen_zero, !empty && degenerate, res_zero, "degenerate result not zeroed")
    `TCP_ASSERT_NEXT(a_mid_q_fill, fq_push, !fq_empty, "front transfer lost at middle queue")
    `TCP_ASSERT_NEXT(a_out_q_fill, oq_push, !empty, "back transfer lost at result queue")
endmodule
`default_nettype wire

// ===== sim/triangle_closest_point_to_origin_core_test.sv =====
// testbench for the triangle closest point core: directed table, then random triangles
// depends on tcp_pkg and triangle_closest_point_to_origin_core
`default_nettype none
module triangle_closest_point_to_origin_core_test
    import tcp_pkg::*;
();

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int N_RANDOM = 1430;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t v [12];
    } tri_t;

    typedef struct {
        logic             degen;
        logic signed [CW:0] cx, cy, cz;
        logic [2*CW-1:0]  dsq;
        logic             ins;
        logic             vis;
    } closest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    coord_t drv [12] = '{default: '0};
    logic full, empty, degenerate, inside_res, visible;
    logic signed [CW:0] closest_x, closest_y, closest_z;
    logic [2*CW-1:0] distance_sq;

    closest_t expected_q [$];
    int errors = 0;
    longint cycles = 0;
    bit no_idle = 1'b0;
    bit accepting = 1'b0;

    always #10 clk = ~clk;

    triangle_closest_point_to_origin_core u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .a_x(drv[0]), .a_y(drv[1]), .a_z(drv[2]),
        .b_x(drv[3]), .b_y(drv[4]), .b_z(drv[5]),
        .c_x(drv[6]), .c_y(drv[7]), .c_z(drv[8]),
        .query_x(drv[9]), .query_y(drv[10]), .query_z(drv[11]),
        .empty(empty), .pop(pop), .degenerate(degenerate),
        .closest_x(closest_x), .closest_y(closest_y), .closest_z(closest_z),
        .distance_sq(distance_sq), .inside_res(inside_res), .visible(visible)
    );

    // floor of x / 2^FB
    function automatic longint floor_frac(longint x);
        return x >>> FB;
    endfunction

    // closest plane point, flags and squared length for one triangle
    function automatic closest_t closest_point(tri_t t);
        closest_t r;
        longint a [3], b [3], c [3], q [3], e1 [3], e2 [3], cp [3];
        longint d11, d12, d22, p1, p2, det, l1, l2, num, p, vdot;
        longint unsigned dsq;
        r = '{degen: 1'b0, cx: '0, cy: '0, cz: '0, dsq: '0, ins: 1'b0, vis: 1'b0};
        dsq = 0;
        vdot = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'(t.v[i]);
            b[i] = longint'(t.v[3+i]);
            c[i] = longint'(t.v[6+i]);
            q[i] = longint'(t.v[9+i]);
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
        end
        d11 = floor_frac(e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2]);
        d12 = floor_frac(e1[0]*e2[0] + e1[1]*e2[1] + e1[2]*e2[2]);
        d22 = floor_frac(e2[0]*e2[0] + e2[1]*e2[1] + e2[2]*e2[2]);
        p1 = floor_frac(a[0]*e1[0] + a[1]*e1[1] + a[2]*e1[2]);
        p2 = floor_frac(a[0]*e2[0] + a[1]*e2[1] + a[2]*e2[2]);
        det = d11*d22 - d12*d12;
        l1 = p2*d12 - p1*d22;
        l2 = p1*d12 - p2*d11;
        if (det <= 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            num = e1[i]*l1 + e2[i]*l2;
            p = a[i] + num / det;
            if (p > (64'sd1 <<< CW) - 1) p = (64'sd1 <<< CW) - 1;
            if (p < -(64'sd1 <<< CW)) p = -(64'sd1 <<< CW);
            cp[i] = p;
            dsq += longint'(p*p);
            vdot += p * (q[i] - p);
        end
        if (dsq > 64'hFFFF_FFFF) dsq = 64'hFFFF_FFFF;
        r.cx = cp[0][CW:0];
        r.cy = cp[1][CW:0];
        r.cz = cp[2][CW:0];
        r.dsq = dsq[2*CW-1:0];
        r.ins = (l1 >= 0 && l2 >= 0 && l1 + l2 <= det);
        r.vis = (vdot > 0);
        return r;
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("triangle_closest_point_to_origin_core_test failed");
            $finish;
        end
    end

    // result side: check each transfer, random pop stalls in bursts
    int pop_idle = 0;
    always @(posedge clk)
    begin
        closest_t e;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (degenerate !== e.degen)
                begin $error("degenerate exp %0d got %0d", e.degen, degenerate); errors++; end
                if (closest_x !== e.cx)
                begin $error("closest_x exp %0d got %0d", e.cx, closest_x); errors++; end
                if (closest_y !== e.cy)
                begin $error("closest_y exp %0d got %0d", e.cy, closest_y); errors++; end
                if (closest_z !== e.cz)
                begin $error("closest_z exp %0d got %0d", e.cz, closest_z); errors++; end
                if (distance_sq !== e.dsq)
                begin $error("distance_sq exp %0d got %0d", e.dsq, distance_sq); errors++; end
                if (inside_res !== e.ins)
                begin $error("inside_res exp %0d got %0d", e.ins, inside_res); errors++; end
                if (visible !== e.vis)
                begin $error("visible exp %0d got %0d", e.vis, visible); errors++; end
            end
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_idle > 0)
        begin
            pop_idle <= pop_idle - 1;
            pop <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            pop_idle <= $urandom_range(0, 2);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // one input transfer, with an optional idle burst first
    task automatic send_triangle(tri_t t);
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        for (int i = 0; i < 12; i++) drv[i] <= t.v[i];
        push <= 1'b1;
        do @(posedge clk); while (full);
        expected_q.push_back(closest_point(t));
    endtask

    // random coordinate: often small, sometimes full range or an extreme
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return coord_t'($signed($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    function automatic tri_t rand_triangle();
        tri_t t;
        int k;
        for (int i = 0; i < 12; i++) t.v[i] = rand_coord();
        k = $urandom_range(0, 9);
        // repeated vertices to hit the degenerate path
        if (k == 0)
            for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
        else if (k == 1)
            for (int i = 0; i < 3; i++) t.v[3+i] = t.v[i];
        return t;
    endfunction

    // directed rows: vertices a, b, c and query point
    localparam int N_DIR = 12;
    coord_t dir_tab [N_DIR][12] = '{
        '{0,0,0, 0,0,0, 0,0,0, 0,0,0},
        '{4096,0,0, 0,4096,0, 0,0,4096, 4096,4096,4096},
        '{4096,0,0, 0,4096,0, 0,0,4096, 0,0,0},
        '{-4096,0,0, 0,-4096,0, 0,0,-4096, -8192,-8192,-8192},
        '{16'sh7fff,16'sh7fff,16'sh7fff, 16'sh8000,16'sh8000,16'sh8000,
          16'sh7fff,16'sh8000,16'sh7fff, 16'sh8000,16'sh7fff,16'sh8000},
        '{16'sh8000,0,0, 0,16'sh8000,0, 0,0,16'sh8000, 16'sh7fff,16'sh7fff,16'sh7fff},
        '{16'sh7fff,0,0, 0,16'sh7fff,0, 0,0,16'sh7fff, -1,-1,-1},
        '{8192,8192,4096, 12288,8192,4096, 8192,12288,4096, 0,0,16'sh7fff},
        '{16'sh7fff,16'sh7fff,0, 16'sh8000,16'sh7fff,0, 16'sh7fff,16'sh8000,1, 0,0,0},
        '{1,2,3, 2,4,6, 3,6,9, 5,5,5},
        '{-1,-1,-1, 16'sh7fff,0,-1, 0,16'sh7fff,16'sh8000, 16'sh8000,16'sh8000,16'sh7fff},
        '{20000,-3000,100, -20000,3000,100, 100,100,-20000, 1,-1,1}
    };

    initial
    begin
        tri_t t;
        closest_t degen_exp;
        push <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the all-zero triangle is read off as degenerate
        for (int r = 0; r < N_DIR; r++)
        begin
            for (int i = 0; i < 12; i++) t.v[i] = dir_tab[r][i];
            send_triangle(t);
            if (r == 0)
            begin
                degen_exp = '{degen: 1'b1, cx: '0, cy: '0, cz: '0, dsq: '0,
                              ins: 1'b0, vis: 1'b0};
                expected_q[expected_q.size()-1] = degen_exp;
            end
        end

        // random part, with one full drain partway through
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
            begin
                push <= 1'b0;
                do @(posedge clk); while (expected_q.size() != 0);
            end
            if (n == N_RANDOM - 200)
                no_idle = 1'b1;
            send_triangle(rand_triangle());
        end
        push <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("triangle_closest_point_to_origin_core_test passed");
        else
            $display("triangle_closest_point_to_origin_core_test failed");
        $finish;
    end

    // a result arriving after the queue drained is caught by the checker above
endmodule
`default_nettype wire
